/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int LAST_ROW_BASE  = CELL_COUNT - SCREEN_COLUMNS;
  localparam int CELL_W         = $clog2(CELL_COUNT);

  // Field widths
  localparam int OP_W        = 2;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_DATA_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE       = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE         = 8'd32;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_PUT     = 3'd0,
    CMD_NEWLINE = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_READ    = 3'd3,
    CMD_NOP     = 3'd4
  } cmd_kind_t;

  typedef enum logic [1:0] {
    SWP_INIT   = 2'd0,
    SWP_SCROLL = 2'd1,
    SWP_CLEAR  = 2'd2
  } sweep_mode_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              use_cursor;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } cmd_t;

endpackage

/* rtl/tcw_ram.sv */
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tcw_front.sv */
`timescale 1ns / 1ps

module tcw_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata,
  input  logic                          hold,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::OP_W-1:0]      operation,
  input  logic [tcw_pkg::CHAR_W-1:0]    character,
  input  logic                          use_cursor,
  input  logic [tcw_pkg::COL_W-1:0]     column,
  input  logic [tcw_pkg::ROW_W-1:0]     line,
  input  logic [tcw_pkg::ATTR_W-1:0]    attribute,
  output logic                          push_valid,
  input  logic                          push_ready,
  output tcw_pkg::cmd_t                 push_cmd,
  output logic [tcw_pkg::ATTR_W-1:0]    default_attribute
);

  logic [tcw_pkg::COL_W-1:0] sat_col;
  logic [tcw_pkg::ROW_W-1:0] sat_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attribute <= tcw_pkg::DEFAULT_ATTR_RESET;
    end else if (cfg_we) begin
      default_attribute <= cfg_wdata;
    end
  end

  // Saturate out-of-range coordinates to the last column / row
  assign sat_col = (column > tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1)) ?
                   tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1) : column;
  assign sat_row = (line > tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1)) ?
                   tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1) : line;

  always_comb begin
    push_cmd.use_cursor = 1'b0;
    push_cmd.col        = sat_col;
    push_cmd.row        = sat_row;
    push_cmd.ch         = character;
    push_cmd.attr       = (attribute == '0) ? default_attribute : attribute;
    unique case (tcw_pkg::op_t'(operation))
      tcw_pkg::OP_PUT: begin
        push_cmd.use_cursor = use_cursor;
        push_cmd.kind = (character == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::CMD_NEWLINE :
                                                               tcw_pkg::CMD_PUT;
      end
      tcw_pkg::OP_CLEAR: push_cmd.kind = tcw_pkg::CMD_CLEAR;
      tcw_pkg::OP_READ:  push_cmd.kind = tcw_pkg::CMD_READ;
      default:           push_cmd.kind = tcw_pkg::CMD_NOP;
    endcase
  end

  // Hold off input while the back end clears the buffer after reset
  assign in_ready   = push_ready && !hold;
  assign push_valid = in_valid && !hold;

endmodule

/* rtl/tcw_queue.sv */
`timescale 1ns / 1ps

module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tcw_pkg::cmd_t pop_cmd
);

  tcw_pkg::cmd_t               entries [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = (count != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/tcw_back.sv */
`timescale 1ns / 1ps

module tcw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  tcw_pkg::cmd_t                 cmd,
  input  logic [tcw_pkg::ATTR_W-1:0]    default_attribute,
  output logic                          init_busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::COL_W-1:0]     cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_line,
  output logic [tcw_pkg::CHAR_W-1:0]    cell_character,
  output logic [tcw_pkg::ATTR_W-1:0]    cell_attribute,
  output logic                          scrolled
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_RDATA = 5'b00100,
    S_SWEEP = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t                      state;
  tcw_pkg::sweep_mode_t        sweep_mode;
  logic [tcw_pkg::CELL_W-1:0]  sweep_idx;
  logic                        sweep_run;
  logic                        wr_go;
  logic [tcw_pkg::CELL_W-1:0]  wr_idx;

  logic [tcw_pkg::COL_W-1:0]   cur_col;
  logic [tcw_pkg::ROW_W-1:0]   cur_row;

  tcw_pkg::cmd_kind_t          kind;
  logic [tcw_pkg::COL_W-1:0]   tgt_col;
  logic [tcw_pkg::ROW_W-1:0]   tgt_row;
  logic [tcw_pkg::CHAR_W-1:0]  ch;
  logic [tcw_pkg::ATTR_W-1:0]  attr;

  logic [tcw_pkg::CHAR_W-1:0]  res_char;
  logic [tcw_pkg::ATTR_W-1:0]  res_attr;
  logic                        res_scroll;

  logic                          ram_we;
  logic [tcw_pkg::CELL_W-1:0]    ram_waddr;
  logic [tcw_pkg::CELL_DATA_W-1:0] ram_wdata;
  logic [tcw_pkg::CELL_W-1:0]    ram_raddr;
  logic [tcw_pkg::CELL_DATA_W-1:0] ram_rdata;

  logic [tcw_pkg::CELL_W-1:0]  exec_addr;
  logic [tcw_pkg::CELL_W-1:0]  sweep_raddr;
  logic                        last_col;
  logic                        last_row;
  logic                        out_free;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_DATA_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign exec_addr = tcw_pkg::CELL_W'(tgt_row) * tcw_pkg::CELL_W'(tcw_pkg::SCREEN_COLUMNS) +
                     tcw_pkg::CELL_W'(tgt_col);
  // Scroll reads one row ahead of the write
  assign sweep_raddr = (sweep_idx < tcw_pkg::CELL_W'(tcw_pkg::LAST_ROW_BASE)) ?
                       sweep_idx + tcw_pkg::CELL_W'(tcw_pkg::SCREEN_COLUMNS) : sweep_idx;
  assign last_col  = (kind == tcw_pkg::CMD_NEWLINE) ||
                     (tgt_col == tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1));
  assign last_row  = (tgt_row == tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1));
  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == S_IDLE);
  assign init_busy = (state == S_SWEEP) && (sweep_mode == tcw_pkg::SWP_INIT);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = exec_addr;
    ram_wdata = {attr, ch};
    ram_raddr = exec_addr;
    if (state == S_EXEC) begin
      ram_we = (kind == tcw_pkg::CMD_PUT);
    end else if (state == S_SWEEP) begin
      ram_raddr = sweep_raddr;
      ram_waddr = wr_idx;
      ram_we    = wr_go;
      if (wr_idx >= tcw_pkg::CELL_W'(tcw_pkg::LAST_ROW_BASE)) begin
        ram_wdata = '0;
      end else begin
        case (sweep_mode)
          tcw_pkg::SWP_SCROLL: ram_wdata = ram_rdata;
          tcw_pkg::SWP_CLEAR:  ram_wdata = {default_attribute, tcw_pkg::SPACE_CODE};
          default:             ram_wdata = '0;
        endcase
      end
    end
  end

  // Raise on a finished result, drop once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_mode <= tcw_pkg::SWP_INIT;
      sweep_idx  <= '0;
      sweep_run  <= 1'b1;
      wr_go      <= 1'b0;
      cur_col    <= '0;
      cur_row    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            kind    <= cmd.kind;
            ch      <= cmd.ch;
            attr    <= cmd.attr;
            tgt_col <= cmd.use_cursor ? cur_col : cmd.col;
            tgt_row <= cmd.use_cursor ? cur_row : cmd.row;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_char <= '0;
          res_attr <= '0;
          case (kind)
            tcw_pkg::CMD_PUT, tcw_pkg::CMD_NEWLINE: begin
              if (!last_col) begin
                cur_col    <= tgt_col + 1'b1;
                cur_row    <= tgt_row;
                res_scroll <= 1'b0;
                state      <= S_RESP;
              end else if (!last_row) begin
                cur_col    <= '0;
                cur_row    <= tgt_row + 1'b1;
                res_scroll <= 1'b0;
                state      <= S_RESP;
              end else begin
                // Past the last cell: cursor stays on the bottom row
                cur_col    <= '0;
                cur_row    <= tgt_row;
                res_scroll <= 1'b1;
                sweep_mode <= tcw_pkg::SWP_SCROLL;
                sweep_idx  <= '0;
                sweep_run  <= 1'b1;
                wr_go      <= 1'b0;
                state      <= S_SWEEP;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              cur_col    <= '0;
              cur_row    <= '0;
              res_scroll <= 1'b1;
              sweep_mode <= tcw_pkg::SWP_CLEAR;
              sweep_idx  <= '0;
              sweep_run  <= 1'b1;
              wr_go      <= 1'b0;
              state      <= S_SWEEP;
            end
            tcw_pkg::CMD_READ: begin
              res_scroll <= 1'b0;
              state      <= S_RDATA;
            end
            default: begin
              res_scroll <= 1'b0;
              state      <= S_RESP;
            end
          endcase
        end
        S_RDATA: begin
          res_char <= ram_rdata[tcw_pkg::CHAR_W-1:0];
          res_attr <= ram_rdata[tcw_pkg::CELL_DATA_W-1:tcw_pkg::CHAR_W];
          state    <= S_RESP;
        end
        S_SWEEP: begin
          wr_go  <= sweep_run;
          wr_idx <= sweep_idx;
          if (sweep_run) begin
            if (sweep_idx == tcw_pkg::CELL_W'(tcw_pkg::CELL_COUNT - 1)) begin
              sweep_run <= 1'b0;
            end else begin
              sweep_idx <= sweep_idx + 1'b1;
            end
          end
          if (wr_go && (wr_idx == tcw_pkg::CELL_W'(tcw_pkg::CELL_COUNT - 1))) begin
            state <= (sweep_mode == tcw_pkg::SWP_INIT) ? S_IDLE : S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            cursor_column  <= cur_col;
            cursor_line    <= cur_row;
            cell_character <= res_char;
            cell_attribute <= res_attr;
            scrolled       <= res_scroll;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/text_console_writer_core.sv */
`timescale 1ns / 1ps

// Text-mode console engine: an 80x25 buffer of character+attribute cells and a cursor.
// Input channel (in_valid/in_ready) carries one operation per transaction: put a
// character (at the cursor or a given cell), clear the screen, or read one cell.
// Output channel (out_valid/out_ready) returns one result per transaction: the cursor
// after the operation, the read cell (zero otherwise) and a scroll flag.
// cfg_we/cfg_wdata write the default attribute (reset 15); write it only while idle.
// The back end executes one command at a time; a two-entry command queue lets the
// input side run ahead while the back end works.
// Scrolls and clears walk every buffer cell through the single write port of the cell
// memory, one per cycle; during the sweep the queue fills and in_ready drops.
// Reset: cursor homes, default attribute becomes 15, and a clearing pass zeroes the
// buffer; in_ready stays low until it finishes.
// A stalled receiver holds the output register; the back end then waits with the
// next finished result, and input stalls once the queue is full.

module text_console_writer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::OP_W-1:0]      operation,
  input  logic [tcw_pkg::CHAR_W-1:0]    character,
  input  logic                          use_cursor,
  input  logic [tcw_pkg::COL_W-1:0]     column,
  input  logic [tcw_pkg::ROW_W-1:0]     line,
  input  logic [tcw_pkg::ATTR_W-1:0]    attribute,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::COL_W-1:0]     cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_line,
  output logic [tcw_pkg::CHAR_W-1:0]    cell_character,
  output logic [tcw_pkg::ATTR_W-1:0]    cell_attribute,
  output logic                          scrolled
);

  // Front end -> queue
  logic                       push_valid;
  logic                       push_ready;
  tcw_pkg::cmd_t              push_cmd;
  // Queue -> back end
  logic                       pop_valid;
  logic                       pop_ready;
  tcw_pkg::cmd_t              pop_cmd;
  logic [tcw_pkg::ATTR_W-1:0] default_attribute;
  logic                       init_busy;

  // Classify incoming transactions and hold the default attribute
  tcw_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .hold              (init_busy),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (operation),
    .character         (character),
    .use_cursor        (use_cursor),
    .column            (column),
    .line              (line),
    .attribute         (attribute),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_cmd          (push_cmd),
    .default_attribute (default_attribute)
  );

  // Decouple the input side from long scroll/clear sweeps
  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Execute commands against the cell memory and drive the result register
  tcw_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (pop_valid),
    .cmd_ready         (pop_ready),
    .cmd               (pop_cmd),
    .default_attribute (default_attribute),
    .init_busy         (init_busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .cursor_column     (cursor_column),
    .cursor_line       (cursor_line),
    .cell_character    (cell_character),
    .cell_attribute    (cell_attribute),
    .scrolled          (scrolled)
  );

  // No transaction may enter while the buffer is still being cleared after reset
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !in_ready)
    else $error("input accepted during clearing pass");

  // Reported cursor always lies on the screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_column <= tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1)) &&
                  (cursor_line <= tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1)))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the bottom row, or home after a clear
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> (cursor_column == '0) &&
      ((cursor_line == tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1)) || (cursor_line == '0)))
    else $error("bad cursor after scroll");

  // A read that returns a non-zero cell never reports a scroll
  a_read_no_scroll: assert property (@(posedge clk) disable iff (rst)
    ((cell_character != '0) || (cell_attribute != '0)) && out_valid |-> !scrolled)
    else $error("read result flagged as scroll");

endmodule

/* tb/tcw_console_checker.sv */
`timescale 1ns / 1ps

module tcw_console_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [tcw_pkg::OP_W-1:0]   operation,
  input  logic [tcw_pkg::CHAR_W-1:0] character,
  input  logic                       use_cursor,
  input  logic [tcw_pkg::COL_W-1:0]  column,
  input  logic [tcw_pkg::ROW_W-1:0]  line,
  input  logic [tcw_pkg::ATTR_W-1:0] attribute,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [tcw_pkg::COL_W-1:0]  cursor_column,
  input  logic [tcw_pkg::ROW_W-1:0]  cursor_line,
  input  logic [tcw_pkg::CHAR_W-1:0] cell_character,
  input  logic [tcw_pkg::ATTR_W-1:0] cell_attribute,
  input  logic                       scrolled,
  output int unsigned                fail_count,
  output int unsigned                pending_count
);
  import tcw_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic              scrolled;
  } cursor_report_t;

  logic [CELL_DATA_W-1:0] screen_cells [CELL_COUNT];
  int unsigned            cursor_pos;
  logic [ATTR_W-1:0]      fill_attr;
  cursor_report_t         expected_reports [$];

  // Move rows up by one and blank the bottom row.
  function automatic void scroll_screen();
    for (int i = 0; i < LAST_ROW_BASE; i++) screen_cells[i] = screen_cells[i + SCREEN_COLUMNS];
    for (int i = LAST_ROW_BASE; i < CELL_COUNT; i++) screen_cells[i] = '0;
  endfunction

  function automatic int unsigned step_past(input int unsigned pos, inout logic wrapped);
    if (pos + 1 < CELL_COUNT) return pos + 1;
    scroll_screen();
    wrapped = 1'b1;
    return pos + 1 - SCREEN_COLUMNS;
  endfunction

  // Saturate column and row onto the screen.
  function automatic int unsigned cell_index(input logic [COL_W-1:0] col,
                                             input logic [ROW_W-1:0] row);
    int unsigned c;
    int unsigned r;
    c = (col > SCREEN_COLUMNS - 1) ? SCREEN_COLUMNS - 1 : col;
    r = (row > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : row;
    return r * SCREEN_COLUMNS + c;
  endfunction

  function automatic cursor_report_t apply_console_op(input op_t op,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic at_cursor,
                                                      input logic [COL_W-1:0] col,
                                                      input logic [ROW_W-1:0] row,
                                                      input logic [ATTR_W-1:0] attr);
    cursor_report_t    rep;
    int unsigned       pos;
    logic              wrapped;
    logic [ATTR_W-1:0] eff_attr;
    rep = '0;
    wrapped = 1'b0;
    case (op)
      OP_PUT: begin
        eff_attr = (attr == '0) ? fill_attr : attr;
        pos = at_cursor ? cursor_pos : cell_index(col, row);
        if (ch == NEWLINE_CODE) begin
          pos = (pos / SCREEN_COLUMNS) * SCREEN_COLUMNS + SCREEN_COLUMNS - 1;
        end else begin
          screen_cells[pos] = {eff_attr, ch};
        end
        cursor_pos = step_past(pos, wrapped);
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = {fill_attr, SPACE_CODE};
        // the trailing advance scrolls, so the bottom row ends up zero
        pos = step_past(CELL_COUNT - 1, wrapped);
        cursor_pos = 0;
      end
      OP_READ: begin
        {rep.attr, rep.ch} = screen_cells[cell_index(col, row)];
      end
      default: ;
    endcase
    rep.scrolled = wrapped;
    rep.col = COL_W'(cursor_pos % SCREEN_COLUMNS);
    rep.row = ROW_W'(cursor_pos / SCREEN_COLUMNS);
    return rep;
  endfunction

  always @(posedge clk) begin : watch_channels
    cursor_report_t exp_rep;
    cursor_report_t got_rep;
    if (rst) begin
      for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = '0;
      cursor_pos = 0;
      fill_attr = DEFAULT_ATTR_RESET;
      expected_reports.delete();
    end else begin
      if (cfg_we) fill_attr = cfg_wdata;
      if (in_valid && in_ready) begin
        expected_reports.push_back(apply_console_op(op_t'(operation), character, use_cursor,
                                                     column, line, attribute));
      end
      if (out_valid && out_ready) begin
        got_rep = {cursor_column, cursor_line, cell_character, cell_attribute, scrolled};
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result transaction with nothing expected", $realtime);
        end else begin
          exp_rep = expected_reports.pop_front();
          if (got_rep !== exp_rep) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"%0t: mismatch: expected col %0d row %0d char %02h attr %02h scr %0b,",
                        " got col %0d row %0d char %02h attr %02h scr %0b"}, $realtime,
                       exp_rep.col, exp_rep.row, exp_rep.ch, exp_rep.attr, exp_rep.scrolled,
                       got_rep.col, got_rep.row, got_rep.ch, got_rep.attr, got_rep.scrolled);
          end
        end
      end
    end
    pending_count = expected_reports.size();
  end

endmodule

/* tb/tb_text_console_writer_core.sv */
`timescale 1ns / 1ps

module tb_text_console_writer_core;
  import tcw_pkg::*;

  // Length of the one long output stall: far more than the queue can absorb.
  localparam int LONG_HOLD_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] character;
  logic              use_cursor;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  line;
  logic [ATTR_W-1:0] attribute;
  logic              out_valid;
  logic              out_ready;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_line;
  logic [CHAR_W-1:0] cell_character;
  logic [ATTR_W-1:0] cell_attribute;
  logic              scrolled;

  int unsigned fail_count;
  int unsigned pending_count;

  // Idle odds in percent per cycle, changed between phases.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Raised by the stimulus to ask for the one long receiver hold-off.
  logic        long_hold_req;
  // Set by the receiver once it has started that hold-off.
  logic        long_hold_done;

  // Last cell written by a positioned put, so reads can hit live data.
  logic [COL_W-1:0] last_put_col;
  logic [ROW_W-1:0] last_put_line;

  text_console_writer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .character      (character),
    .use_cursor     (use_cursor),
    .column         (column),
    .line           (line),
    .attribute      (attribute),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_column  (cursor_column),
    .cursor_line    (cursor_line),
    .cell_character (cell_character),
    .cell_attribute (cell_attribute),
    .scrolled       (scrolled)
  );

  tcw_console_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .character      (character),
    .use_cursor     (use_cursor),
    .column         (column),
    .line           (line),
    .attribute      (attribute),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_column  (cursor_column),
    .cursor_line    (cursor_line),
    .cell_character (cell_character),
    .cell_attribute (cell_attribute),
    .scrolled       (scrolled),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop. Scrolls and clears each walk the whole buffer, as does the clearing
  // pass after reset; the limit leaves room even if every transaction walked the
  // buffer.
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: accept at random, or hold off for a long stretch on request so
  // the command queue fills and the input side backs up.
  initial begin
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one transaction and hold it until accepted. Enter and leave at a
  // falling edge; valid stays high across back-to-back transactions.
  task automatic send_item(input op_t op, input logic [CHAR_W-1:0] ch, input logic at_cursor,
                           input logic [COL_W-1:0] col, input logic [ROW_W-1:0] ln,
                           input logic [ATTR_W-1:0] attr);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    character  <= ch;
    use_cursor <= at_cursor;
    column     <= col;
    line       <= ln;
    attribute  <= attr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_default_attr(input logic [ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly on screen, now and then past the right edge to exercise saturation.
  function automatic logic [COL_W-1:0] pick_column();
    logic [COL_W-1:0] c;
    if ($urandom_range(0, 99) < 85) c = COL_W'($urandom_range(0, SCREEN_COLUMNS - 2));
    else c = COL_W'($urandom_range(SCREEN_COLUMNS - 1, (1 << COL_W) - 1));
    return c;
  endfunction

  // Keep the bottom row rare: writes there are what trigger scrolls.
  function automatic logic [ROW_W-1:0] pick_line();
    logic [ROW_W-1:0] r;
    if ($urandom_range(0, 99) < 90) r = ROW_W'($urandom_range(0, SCREEN_ROWS - 2));
    else r = ROW_W'($urandom_range(SCREEN_ROWS - 1, (1 << ROW_W) - 1));
    return r;
  endfunction

  function automatic logic [ATTR_W-1:0] pick_attr();
    logic [ATTR_W-1:0] a;
    if ($urandom_range(0, 99) < 15) a = '0;
    else a = ATTR_W'($urandom_range(0, (1 << ATTR_W) - 1));
    return a;
  endfunction

  function automatic logic [CHAR_W-1:0] text_char();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 99) < 6) c = NEWLINE_CODE;
    else c = CHAR_W'($urandom_range(0, (1 << CHAR_W) - 1));
    return c;
  endfunction

  // Random traffic: bursts of text at the cursor, positioned puts, reads (half of
  // them of the cell of the last positioned put), a few clears and some unused-code noise.
  task automatic random_traffic(input int n);
    int               sent;
    int               pick;
    int               burst;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] ln;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        burst = $urandom_range(1, 12);
        repeat (burst) send_item(OP_PUT, text_char(), 1'b1, pick_column(), pick_line(),
                                 pick_attr());
        sent += burst;
      end else if (pick < 62) begin
        col = pick_column();
        ln  = pick_line();
        send_item(OP_PUT, text_char(), 1'b0, col, ln, pick_attr());
        last_put_col  = col;
        last_put_line = ln;
        sent++;
      end else if (pick < 92) begin
        if ($urandom_range(0, 1)) begin
          col = last_put_col;
          ln  = last_put_line;
        end else begin
          col = COL_W'($urandom_range(0, (1 << COL_W) - 1));
          ln  = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
        end
        send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), col, ln,
                  ATTR_W'($urandom_range(0, 255)));
        sent++;
      end else if (pick < 94) begin
        send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  pick_column(), pick_line(), ATTR_W'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_item(OP_NONE, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)),
                  ATTR_W'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // Directed start: corners of every field, every operation, and the special cases.
  task automatic directed_items();
    send_item(OP_READ,  8'h00, 1'b0, 7'd0,   5'd0,  8'h00); // untouched cell reads zero
    send_item(OP_READ,  8'hFF, 1'b1, 7'd127, 5'd31, 8'hFF); // read past both edges
    send_item(OP_PUT,   8'h41, 1'b0, 7'd0,   5'd0,  8'h00); // zero attr takes the default
    send_item(OP_READ,  8'h00, 1'b0, 7'd0,   5'd0,  8'h00);
    send_item(OP_PUT,   8'hFF, 1'b0, 7'd127, 5'd31, 8'hFF); // last cell: scroll
    send_item(OP_READ,  8'h00, 1'b0, 7'd79,  5'd23, 8'h00); // old bottom row moved up
    send_item(OP_READ,  8'h00, 1'b0, 7'd0,   5'd24, 8'h00); // new bottom row is zero
    send_item(OP_PUT,   NEWLINE_CODE, 1'b0, 7'd5, 5'd3, 8'h77); // newline writes nothing
    send_item(OP_READ,  8'h00, 1'b0, 7'd5,   5'd3,  8'h00);
    send_item(OP_PUT,   8'h00, 1'b1, 7'd99,  5'd17, 8'h01); // put at the cursor
    send_item(OP_PUT,   NEWLINE_CODE, 1'b1, 7'd0, 5'd0, 8'h00);
    send_item(OP_NONE,  8'hAA, 1'b1, 7'd127, 5'd31, 8'hFF); // unused code does nothing
    send_item(OP_PUT,   NEWLINE_CODE, 1'b0, 7'd0, 5'd24, 8'h00); // newline on bottom row
    send_item(OP_PUT,   8'h7A, 1'b0, 7'd79,  5'd24, 8'h55); // last column, bottom row
    send_item(OP_CLEAR, 8'h00, 1'b0, 7'd0,   5'd0,  8'h00); // clear: scrolls and homes
    send_item(OP_READ,  8'h00, 1'b0, 7'd0,   5'd0,  8'h00); // space, default attr
    send_item(OP_READ,  8'h00, 1'b0, 7'd10,  5'd24, 8'h00); // bottom row zero after clear
    send_item(OP_READ,  8'h00, 1'b0, 7'd79,  5'd23, 8'h00);
    send_item(OP_PUT,   8'h7F, 1'b1, 7'd0,   5'd0,  8'h80);
    send_item(OP_READ,  8'h00, 1'b0, 7'd0,   5'd0,  8'h00);
    send_item(OP_PUT,   8'h21, 1'b0, 7'd80,  5'd0,  8'h02); // column saturates
    send_item(OP_PUT,   8'h22, 1'b0, 7'd0,   5'd25, 8'h03); // row saturates
    send_item(OP_READ,  8'h00, 1'b0, 7'd127, 5'd0,  8'h00);
    send_item(OP_NONE,  8'h00, 1'b0, 7'd0,   5'd0,  8'h00);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    operation     = OP_PUT;
    character     = '0;
    use_cursor    = 1'b0;
    column        = '0;
    line          = '0;
    attribute     = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b0;
    last_put_col  = '0;
    last_put_line = '0;

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    // Hold off until the clearing pass after reset is done.
    @(negedge clk);
    while (!in_ready) @(negedge clk);

    write_default_attr(8'h3C);
    directed_items();
    drain_results();

    // Light sender gaps, heavy receiver stalls; pause midway until drained.
    write_default_attr(8'hFF);
    send_idle_pct = 7;
    recv_idle_pct = 56;
    random_traffic(250);
    drain_results();
    random_traffic(250);
    drain_results();

    // Heavy sender gaps, light receiver stalls; zero default attribute.
    write_default_attr(8'h00);
    send_idle_pct = 56;
    recv_idle_pct = 7;
    random_traffic(500);
    drain_results();

    // Full rate, opened by one long receiver hold-off to back up the input.
    write_default_attr(ATTR_W'($urandom_range(1, 254)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    random_traffic(500);
    drain_results();

    // Let any stray result surface before the verdict.
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* text_console_writer_core.f */
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer_core.sv
tb/tcw_console_checker.sv
tb/tb_text_console_writer_core.sv
